[rtl/rti_pkg.sv]
package rti_pkg;

  // Field and datapath widths, and the queue depth.
  localparam int CW          = 32;
  localparam int D_W         = 67;
  localparam int E_W         = 66;
  localparam int DEN_W       = 66;
  localparam int NUM_W       = 99;
  localparam int QB          = 34;
  localparam int RW          = DEN_W + QB;
  localparam int LO_W        = 34;
  localparam int C_W         = 67;
  localparam int PR_W        = 2 * C_W;
  localparam int DOT_W       = PR_W + 2;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CW-1:0] DIR_X_RESET = 32'h0001_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Z = 3'd5;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] normal_x;
    logic signed [CW-1:0] normal_y;
    logic signed [CW-1:0] normal_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
  } out_t;

  typedef struct packed {
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dir;
  } ray_t;

  // One classified triangle as it waits between the two halves.
  typedef struct packed {
    logic                  miss;
    logic signed [D_W-1:0] d;
    logic signed [E_W-1:0] e;
    logic [8:0][CW-1:0]    v;
  } qitem_t;

endpackage

[rtl/rti_front.sv]
module rti_front (
  input  logic            clk,
  input  logic            rst_n,
  input  rti_pkg::ray_t   ray,
  input  logic            in_valid,
  output logic            in_ready,
  input  rti_pkg::in_t    in_data,
  output logic            push,
  output rti_pkg::qitem_t push_data,
  input  logic            q_full
);

  localparam int CW  = rti_pkg::CW;
  localparam int D_W = rti_pkg::D_W;
  localparam int E_W = rti_pkg::E_W;

  logic [2:0] vld_r, vld_nxt;
  logic       en;

  rti_pkg::in_t            item_r;
  logic [8:0][CW-1:0]      vtx1, v2_r, v3_r;
  logic [2:0][CW-1:0]      nrm1;
  logic signed [CW:0]      dv;
  logic signed [2*CW:0]    pd_nxt [3];
  logic signed [2*CW:0]    pd_r   [3];
  logic signed [2*CW-1:0]  pe_nxt [3];
  logic signed [2*CW-1:0]  pe_r   [3];
  logic signed [D_W-1:0]   d_nxt, d_r;
  logic signed [E_W-1:0]   e_nxt, e_r;

  assign en       = !vld_r[2] || !q_full;
  assign in_ready = en;
  assign push     = vld_r[2] && !q_full;
  assign vld_nxt  = {vld_r[1:0], in_valid};

  assign vtx1 = {item_r.v2_z, item_r.v2_y, item_r.v2_x,
                 item_r.v1_z, item_r.v1_y, item_r.v1_x,
                 item_r.v0_z, item_r.v0_y, item_r.v0_x};
  assign nrm1 = {item_r.normal_z, item_r.normal_y, item_r.normal_x};

  always_comb begin
    dv = '0;
    for (int k = 0; k < 3; k++) begin
      dv        = $signed(vtx1[k]) - $signed(ray.org[k]);
      pd_nxt[k] = dv * $signed(nrm1[k]);
      pe_nxt[k] = $signed(nrm1[k]) * $signed(ray.dir[k]);
    end
    d_nxt = pd_r[0] + pd_r[1] + pd_r[2];
    e_nxt = pe_r[0] + pe_r[1] + pe_r[2];
  end

  // A plane parallel to the ray, or on or behind the origin, is a miss.
  always_comb begin
    push_data.d    = d_r;
    push_data.e    = e_r;
    push_data.v    = v3_r;
    push_data.miss = (e_r == '0) || (d_r == '0) || (d_r[D_W-1] != e_r[E_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= in_data;
      v2_r   <= vtx1;
      pd_r   <= pd_nxt;
      pe_r   <= pe_nxt;
      v3_r   <= v2_r;
      d_r    <= d_nxt;
      e_r    <= e_nxt;
    end
  end

endmodule

[rtl/rti_queue.sv]
module rti_queue #(
  parameter int DEPTH = rti_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rti_pkg::qitem_t push_data,
  output logic            full,
  input  logic            pop,
  output rti_pkg::qitem_t pop_data,
  output logic            empty
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rti_pkg::qitem_t  mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

[rtl/rti_div.sv]
module rti_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rti_pkg::RW-1:0]    num,
  input  logic [rti_pkg::DEN_W-1:0] den,
  output logic [rti_pkg::QB-1:0]    q,
  output logic                      big
);

  localparam int RW    = rti_pkg::RW;
  localparam int QB    = rti_pkg::QB;
  localparam int DEN_W = rti_pkg::DEN_W;

  logic [RW-1:0]    r_r   [QB+1];
  logic [RW-1:0]    r_nxt [QB+1];
  logic [DEN_W-1:0] den_r [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic [QB-1:0]    q_nxt [QB+1];
  logic             big_r [QB+1];
  logic [RW:0]      diff  [QB+1];
  logic             ge    [QB+1];
  logic [RW-1:0]    dsh;

  // Entry: the quotient overflows the clamp range when num >= den * 2^QB.
  // Each later stage settles one quotient bit, most significant first.
  always_comb begin
    dsh = '0;
    diff[0]  = {1'b0, num} - {1'b0, den, QB'(0)};
    ge[0]    = !diff[0][RW];
    r_nxt[0] = num;
    q_nxt[0] = '0;
    for (int s = 0; s < QB; s++) begin
      dsh          = RW'(den_r[s]) << (QB - 1 - s);
      diff[s+1]    = {1'b0, r_r[s]} - {1'b0, dsh};
      ge[s+1]      = !diff[s+1][RW];
      r_nxt[s+1]   = ge[s+1] ? diff[s+1][RW-1:0] : r_r[s];
      q_nxt[s+1]   = {q_r[s][QB-2:0], ge[s+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= r_nxt[0];
      den_r[0] <= den;
      q_r[0]   <= q_nxt[0];
      big_r[0] <= ge[0];
      for (int s = 1; s <= QB; s++) begin
        r_r[s]   <= r_nxt[s];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= q_nxt[s];
        big_r[s] <= big_r[s-1];
      end
    end
  end

  assign q   = q_r[QB];
  assign big = big_r[QB];

endmodule

[rtl/rti_back.sv]
module rti_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rti_pkg::ray_t   ray,
  input  logic            q_empty,
  output logic            pop,
  input  rti_pkg::qitem_t head,
  output logic            out_valid,
  input  logic            out_ready,
  output rti_pkg::out_t   out_data
);

  localparam int CW      = rti_pkg::CW;
  localparam int D_W     = rti_pkg::D_W;
  localparam int E_W     = rti_pkg::E_W;
  localparam int DEN_W   = rti_pkg::DEN_W;
  localparam int NUM_W   = rti_pkg::NUM_W;
  localparam int QB      = rti_pkg::QB;
  localparam int RW      = rti_pkg::RW;
  localparam int LO_W    = rti_pkg::LO_W;
  localparam int C_W     = rti_pkg::C_W;
  localparam int PR_W    = rti_pkg::PR_W;
  localparam int DOT_W   = rti_pkg::DOT_W;
  localparam int DIV_LAT = QB + 1;
  localparam int NST     = 3 + DIV_LAT + 8;
  localparam logic [QB:0] MAG_SAT = (QB + 1)'(1) << QB;

  typedef struct packed {
    logic               miss;
    logic [8:0][CW-1:0] v;
    logic [2:0]         neg;
  } side_t;

  logic [NST-1:0] vld_r, vld_nxt;
  logic           en;

  // Stage 1: partial products of direction times d, |e|.
  logic signed [CW+LO_W:0]     pp0_nxt [3];
  logic signed [CW+LO_W:0]     pp0_r   [3];
  logic signed [CW+D_W-LO_W-1:0] pp1_nxt [3];
  logic signed [CW+D_W-LO_W-1:0] pp1_r   [3];
  logic [DEN_W-1:0]            den1_nxt, den1_r, den2_r, den3_r;
  logic                        eneg1_r, eneg2_r, miss1_r, miss2_r;
  logic [8:0][CW-1:0]          v1_r, v2_r;

  // Stage 2 and 3: numerators and their magnitudes.
  logic signed [NUM_W-1:0]     num_nxt [3];
  logic signed [NUM_W-1:0]     num_r   [3];
  logic [NUM_W-1:0]            absn_nxt [3];
  logic [NUM_W-1:0]            absn_r   [3];
  side_t                       side3_nxt, side3_r;
  side_t                       sd_r [DIV_LAT];

  logic [QB-1:0]               q   [3];
  logic                        big [3];

  // Plane point and the edge test.
  logic [QB:0]                 mag;
  logic signed [QB+1:0]        off;
  logic signed [CW+QB-CW+CW+4:0] sum;
  logic [2:0][CW-1:0]          p_nxt, p_r, p_a_r, p_m_r, p_c_r, p_d1_r, p_d2_r, p_d3_r;
  logic                        miss_p_r, miss_a_r, miss_m_r, miss_c_r;
  logic                        miss_d1_r, miss_d2_r, miss_d3_r;
  logic [8:0][CW-1:0]          v_p_r;
  logic signed [CW:0]          a_nxt [3][3];
  logic signed [CW:0]          a_r   [3][3];
  logic signed [CW:0]          b_nxt [3][3];
  logic signed [CW:0]          b_r   [3][3];
  logic signed [2*CW+1:0]      m_nxt [3][6];
  logic signed [2*CW+1:0]      m_r   [3][6];
  logic signed [C_W-1:0]       c_nxt [3][3];
  logic signed [C_W-1:0]       c_r   [3][3];
  logic signed [C_W-1:0]       cx, cy;
  logic [2*LO_W-1:0]           ll_nxt [6];
  logic [2*LO_W-1:0]           ll_r   [6];
  logic signed [2*LO_W-1:0]    lh_nxt [6];
  logic signed [2*LO_W-1:0]    lh_r   [6];
  logic signed [2*LO_W-1:0]    hl_nxt [6];
  logic signed [2*LO_W-1:0]    hl_r   [6];
  logic signed [2*(C_W-LO_W)-1:0] hh_nxt [6];
  logic signed [2*(C_W-LO_W)-1:0] hh_r   [6];
  logic signed [2*(C_W-LO_W)-1:0] hh2_r  [6];
  logic [2*LO_W-1:0]           lo_r  [6];
  logic signed [2*LO_W:0]      mid_nxt [6];
  logic signed [2*LO_W:0]      mid_r   [6];
  logic signed [PR_W-1:0]      term_nxt [6];
  logic signed [PR_W-1:0]      term_r   [6];
  logic signed [DOT_W-1:0]     dot0, dot1;
  rti_pkg::out_t               out_nxt, out_r;

  assign en        = !vld_r[NST-1] || out_ready;
  assign pop       = en && !q_empty;
  assign vld_nxt   = {vld_r[NST-2:0], !q_empty};
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  // Front of the pipe: offsets direction * d, split into two partial products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp0_nxt[k]  = $signed(ray.dir[k]) * $signed({1'b0, head.d[LO_W-1:0]});
      pp1_nxt[k]  = $signed(ray.dir[k]) * $signed(head.d[D_W-1:LO_W]);
      num_nxt[k]  = pp0_r[k] + (pp1_r[k] <<< LO_W);
      absn_nxt[k] = num_r[k][NUM_W-1] ? NUM_W'(-num_r[k]) : NUM_W'(num_r[k]);
      side3_nxt.neg[k] = num_r[k][NUM_W-1] ^ eneg2_r;
    end
    den1_nxt       = head.e[E_W-1] ? DEN_W'(-$signed(head.e)) : DEN_W'(head.e);
    side3_nxt.miss = miss2_r;
    side3_nxt.v    = v2_r;
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    rti_div u_div (
      .clk (clk),
      .en  (en),
      .num (RW'(absn_r[k])),
      .den (den3_r),
      .q   (q[k]),
      .big (big[k])
    );
  end

  // Plane point, saturated to the Q16.16 range.
  always_comb begin
    mag = '0;
    off = '0;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      mag = big[k] ? MAG_SAT : {1'b0, q[k]};
      off = sd_r[DIV_LAT-1].neg[k] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      sum = $signed(ray.org[k]) + off;
      if ((sum[$high(sum):CW-1] == '0) || (sum[$high(sum):CW-1] == '1)) begin
        p_nxt[k] = sum[CW-1:0];
      end else if (sum[$high(sum)]) begin
        p_nxt[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        p_nxt[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  // Edge vectors, cross products, and the two sign tests.
  always_comb begin
    cx = '0;
    cy = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        a_nxt[i][k] = $signed(p_r[k]) - $signed(v_p_r[i*3+k]);
        b_nxt[i][k] = $signed(v_p_r[((i == 2) ? 0 : i + 1)*3+k]) - $signed(v_p_r[i*3+k]);
      end
      m_nxt[i][0] = a_r[i][1] * b_r[i][2];
      m_nxt[i][1] = a_r[i][2] * b_r[i][1];
      m_nxt[i][2] = a_r[i][2] * b_r[i][0];
      m_nxt[i][3] = a_r[i][0] * b_r[i][2];
      m_nxt[i][4] = a_r[i][0] * b_r[i][1];
      m_nxt[i][5] = a_r[i][1] * b_r[i][0];
      c_nxt[i][0] = m_r[i][0] - m_r[i][1];
      c_nxt[i][1] = m_r[i][2] - m_r[i][3];
      c_nxt[i][2] = m_r[i][4] - m_r[i][5];
    end
    for (int t = 0; t < 6; t++) begin
      cx = c_r[0][t % 3];
      cy = (t < 3) ? c_r[1][t % 3] : c_r[2][t % 3];
      ll_nxt[t]   = cx[LO_W-1:0] * cy[LO_W-1:0];
      lh_nxt[t]   = $signed({1'b0, cx[LO_W-1:0]}) * $signed(cy[C_W-1:LO_W]);
      hl_nxt[t]   = $signed(cx[C_W-1:LO_W]) * $signed({1'b0, cy[LO_W-1:0]});
      hh_nxt[t]   = $signed(cx[C_W-1:LO_W]) * $signed(cy[C_W-1:LO_W]);
      mid_nxt[t]  = lh_r[t] + hl_r[t];
      term_nxt[t] = $signed({1'b0, lo_r[t]}) + (mid_r[t] <<< LO_W)
                  + (hh2_r[t] <<< (2 * LO_W));
    end
    dot0 = term_r[0] + term_r[1] + term_r[2];
    dot1 = term_r[3] + term_r[4] + term_r[5];
    out_nxt.hit   = !miss_d3_r && !dot0[DOT_W-1] && !dot1[DOT_W-1];
    out_nxt.hit_x = out_nxt.hit ? $signed(p_d3_r[0]) : '0;
    out_nxt.hit_y = out_nxt.hit ? $signed(p_d3_r[1]) : '0;
    out_nxt.hit_z = out_nxt.hit ? $signed(p_d3_r[2]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r   <= pp0_nxt;
      pp1_r   <= pp1_nxt;
      den1_r  <= den1_nxt;
      eneg1_r <= head.e[E_W-1];
      miss1_r <= head.miss;
      v1_r    <= head.v;

      num_r   <= num_nxt;
      den2_r  <= den1_r;
      eneg2_r <= eneg1_r;
      miss2_r <= miss1_r;
      v2_r    <= v1_r;

      absn_r  <= absn_nxt;
      den3_r  <= den2_r;
      side3_r <= side3_nxt;

      sd_r[0] <= side3_r;
      for (int s = 1; s < DIV_LAT; s++) begin
        sd_r[s] <= sd_r[s-1];
      end

      p_r      <= p_nxt;
      miss_p_r <= sd_r[DIV_LAT-1].miss;
      v_p_r    <= sd_r[DIV_LAT-1].v;

      a_r      <= a_nxt;
      b_r      <= b_nxt;
      p_a_r    <= p_r;
      miss_a_r <= miss_p_r;

      m_r      <= m_nxt;
      p_m_r    <= p_a_r;
      miss_m_r <= miss_a_r;

      c_r      <= c_nxt;
      p_c_r    <= p_m_r;
      miss_c_r <= miss_m_r;

      ll_r      <= ll_nxt;
      lh_r      <= lh_nxt;
      hl_r      <= hl_nxt;
      hh_r      <= hh_nxt;
      p_d1_r    <= p_c_r;
      miss_d1_r <= miss_c_r;

      lo_r      <= ll_r;
      mid_r     <= mid_nxt;
      hh2_r     <= hh_r;
      p_d2_r    <= p_d1_r;
      miss_d2_r <= miss_d1_r;

      term_r    <= term_nxt;
      p_d3_r    <= p_d2_r;
      miss_d3_r <= miss_d2_r;

      out_r     <= out_nxt;
    end
  end

endmodule

[rtl/ray_triangle_intersection_unit.sv]
// Channel   Handshake              Beat contents
// in_       in_valid / in_ready    one triangle: three vertices and a plane normal
// out_      out_valid / out_ready  hit flag and the Q16.16 hit point
// cfg_      cfg_valid / cfg_ready  register index and 32-bit data (ray origin, direction)
//
// One triangle is accepted per cycle while the front is not stalled; each result
// passes through the 35-stage quotient pipelines that follow the plane test.
// Reset is synchronous and active low; it clears the pipeline valids, the
// queue pointers and the ray registers (origin 0, direction +x).
// The front stalls only when the queue between the halves is full, and the
// back only when its output register holds a beat that is not taken.
module ray_triangle_intersection_unit #(
  parameter int QUEUE_DEPTH = rti_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rti_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rti_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rti_pkg::CW-1:0]        cfg_data
);

  rti_pkg::ray_t   ray_r, ray_nxt;
  logic            push, pop, q_full, q_empty;
  rti_pkg::qitem_t push_data, head;

  // Register writes are always taken; indexes beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    ray_nxt = ray_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rti_pkg::REG_ORIGIN_X:    ray_nxt.org[0] = cfg_data;
        rti_pkg::REG_ORIGIN_Y:    ray_nxt.org[1] = cfg_data;
        rti_pkg::REG_ORIGIN_Z:    ray_nxt.org[2] = cfg_data;
        rti_pkg::REG_DIRECTION_X: ray_nxt.dir[0] = cfg_data;
        rti_pkg::REG_DIRECTION_Y: ray_nxt.dir[1] = cfg_data;
        rti_pkg::REG_DIRECTION_Z: ray_nxt.dir[2] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.org <= '0;
      ray_r.dir <= {{(2*rti_pkg::CW){1'b0}}, rti_pkg::DIR_X_RESET};
    end else begin
      ray_r <= ray_nxt;
    end
  end

  // The front forms d and e for each triangle and flags the plane misses.
  rti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  rti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  // The back divides out the hit point and runs the inside test.
  rti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .q_empty   (q_empty),
    .pop       (pop),
    .head      (head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the ray / triangle intersection unit. Triangles are
// queued by the stimulus process and fed by a clocked driver; a clocked monitor
// compares every output beat against a scoreboard of predicted results.
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int ITEMS_PER_RUN  = 275;

  typedef logic signed [199:0] wide_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  rti_pkg::in_t                  in_data;
  logic                          out_valid;
  logic                          out_ready;
  rti_pkg::out_t                 out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rti_pkg::CW-1:0]        cfg_data;

  // Ray as the predictor sees it; updated on each accepted register beat.
  logic signed [rti_pkg::CW-1:0] ray_org [3];
  logic signed [rti_pkg::CW-1:0] ray_dir [3];

  rti_pkg::in_t  triangle_q [$];
  rti_pkg::out_t hit_expected_q [$];
  int            idle_mode;
  int            error_count = 0;
  int            stall_count;

  ray_triangle_intersection_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact intersection: products and sums are carried wide, only the
  // quotient truncates, and the point saturates before the inside test.
  function automatic rti_pkg::out_t predict_hit(rti_pkg::in_t t);
    wide_t o [3];
    wide_t r [3];
    wide_t v [3][3];
    wide_t n [3];
    wide_t p [3];
    wide_t a [3];
    wide_t b [3];
    wide_t c [3][3];
    wide_t d, e, den, num, dot0, dot1, mag;
    logic [199:0] q;
    logic neg;
    rti_pkg::out_t res;
    int j;
    res = '0;
    v[0][0] = $signed(t.v0_x); v[0][1] = $signed(t.v0_y); v[0][2] = $signed(t.v0_z);
    v[1][0] = $signed(t.v1_x); v[1][1] = $signed(t.v1_y); v[1][2] = $signed(t.v1_z);
    v[2][0] = $signed(t.v2_x); v[2][1] = $signed(t.v2_y); v[2][2] = $signed(t.v2_z);
    n[0] = $signed(t.normal_x); n[1] = $signed(t.normal_y); n[2] = $signed(t.normal_z);
    d = 0;
    e = 0;
    for (int k = 0; k < 3; k++) begin
      o[k] = ray_org[k];
      r[k] = ray_dir[k];
      d = d + (v[0][k] - o[k]) * n[k];
      e = e + n[k] * r[k];
    end
    // Parallel ray, or plane on or behind the origin.
    if (e == 0 || d == 0 || ((d < 0) != (e < 0))) return res;
    den = (e < 0) ? -e : e;
    for (int k = 0; k < 3; k++) begin
      num = r[k] * d;
      neg = (num < 0) != (e < 0);
      q = ((num < 0) ? -num : num) / den;
      mag = (q >= (200'd1 << 34)) ? (wide_t'(1) <<< 34) : $signed(q);
      p[k] = o[k] + (neg ? -mag : mag);
      if (p[k] > 64'sd2147483647) p[k] = 64'sd2147483647;
      if (p[k] < -64'sd2147483648) p[k] = -64'sd2147483648;
    end
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      for (int k = 0; k < 3; k++) begin
        a[k] = p[k] - v[i][k];
        b[k] = v[j][k] - v[i][k];
      end
      c[i][0] = a[1] * b[2] - a[2] * b[1];
      c[i][1] = a[2] * b[0] - a[0] * b[2];
      c[i][2] = a[0] * b[1] - a[1] * b[0];
    end
    dot0 = c[0][0] * c[1][0] + c[0][1] * c[1][1] + c[0][2] * c[1][2];
    dot1 = c[0][0] * c[2][0] + c[0][1] * c[2][1] + c[0][2] * c[2][2];
    if (dot0 < 0 || dot1 < 0) return res;
    res.hit   = 1'b1;
    res.hit_x = p[0][rti_pkg::CW-1:0];
    res.hit_y = p[1][rti_pkg::CW-1:0];
    res.hit_z = p[2][rti_pkg::CW-1:0];
    return res;
  endfunction

  function automatic bit idle_now(bit is_sender);
    int pct;
    pct = 0;
    if (idle_mode == 0) pct = is_sender ? 16 : 48;
    if (idle_mode == 1) pct = is_sender ? 48 : 16;
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: a new beat is presented only once the previous one was taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) hit_expected_q.push_back(predict_hit(in_data));
      if (!in_valid || in_ready) begin
        if (triangle_q.size() > 0 && !idle_now(1'b1)) begin
          in_data  <= triangle_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken output beat against the oldest prediction.
  always @(posedge clk) begin
    rti_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hit_expected_q.size() == 0) begin
          $error("output beat with no prediction pending");
          error_count++;
        end else begin
          want = hit_expected_q.pop_front();
          if (out_data.hit !== want.hit) begin
            $error("hit expected %0d got %0d", want.hit, out_data.hit);
            error_count++;
          end
          if (out_data.hit_x !== want.hit_x) begin
            $error("hit_x expected %0d got %0d", want.hit_x, out_data.hit_x);
            error_count++;
          end
          if (out_data.hit_y !== want.hit_y) begin
            $error("hit_y expected %0d got %0d", want.hit_y, out_data.hit_y);
            error_count++;
          end
          if (out_data.hit_z !== want.hit_z) begin
            $error("hit_z expected %0d got %0d", want.hit_z, out_data.hit_z);
            error_count++;
          end
        end
      end
      out_ready <= !idle_now(1'b0);
    end
  end

  // Watchdog: any cycle with no beat on any channel counts toward the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [rti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rti_pkg::CW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= rti_pkg::REG_ORIGIN_Z) ray_org[idx] = value;
    else if (idx <= rti_pkg::REG_DIRECTION_Z) ray_dir[idx - rti_pkg::REG_DIRECTION_X] = value;
  endtask

  task automatic set_ray(input logic [rti_pkg::CW-1:0] ox, oy, oz, dx, dy, dz);
    write_reg(rti_pkg::REG_ORIGIN_X, ox);
    write_reg(rti_pkg::REG_ORIGIN_Y, oy);
    write_reg(rti_pkg::REG_ORIGIN_Z, oz);
    write_reg(rti_pkg::REG_DIRECTION_X, dx);
    write_reg(rti_pkg::REG_DIRECTION_Y, dy);
    write_reg(rti_pkg::REG_DIRECTION_Z, dz);
  endtask

  // Holds the sender until every predicted beat has come back, then lets the
  // back half of the pipeline empty before anything else changes. The check
  // repeats after the quiet period so a beat launched in the same cycle as
  // the first check is never left behind.
  task automatic drain;
    do begin
      while (triangle_q.size() > 0 || in_valid || hit_expected_q.size() > 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (triangle_q.size() > 0 || in_valid || hit_expected_q.size() > 0);
  endtask

  function automatic logic [rti_pkg::CW-1:0] small_val(int span);
    return rti_pkg::CW'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic rti_pkg::in_t make_tri(logic [rti_pkg::CW-1:0] x0, y0, z0, x1, y1, z1,
                                            x2, y2, z2, nx, ny, nz);
    rti_pkg::in_t t;
    t = {x0, y0, z0, x1, y1, z1, x2, y2, z2, nx, ny, nz};
    return t;
  endfunction

  // A triangle placed around a point on the current ray, with a normal built
  // from its edges, so that most of them are hit or narrowly missed.
  function automatic rti_pkg::in_t ray_tri();
    longint ctr [3];
    longint ofs [3][3];
    longint nrm [3];
    logic [rti_pkg::CW-1:0] vv [3][3];
    int steps;
    int span;
    steps = $urandom_range(1, 8);
    span = 1 << $urandom_range(12, 20);
    for (int k = 0; k < 3; k++) begin
      ctr[k] = longint'(ray_org[k]) + longint'(ray_dir[k]) * steps;
      for (int i = 0; i < 3; i++) begin
        ofs[i][k] = int'($urandom_range(0, 2 * span)) - span;
        vv[i][k] = rti_pkg::CW'(ctr[k] + ofs[i][k]);
      end
    end
    nrm[0] = ((ofs[1][1] - ofs[0][1]) * (ofs[2][2] - ofs[0][2]) -
              (ofs[1][2] - ofs[0][2]) * (ofs[2][1] - ofs[0][1])) >>> 12;
    nrm[1] = ((ofs[1][2] - ofs[0][2]) * (ofs[2][0] - ofs[0][0]) -
              (ofs[1][0] - ofs[0][0]) * (ofs[2][2] - ofs[0][2])) >>> 12;
    nrm[2] = ((ofs[1][0] - ofs[0][0]) * (ofs[2][1] - ofs[0][1]) -
              (ofs[1][1] - ofs[0][1]) * (ofs[2][0] - ofs[0][0])) >>> 12;
    return make_tri(vv[0][0], vv[0][1], vv[0][2], vv[1][0], vv[1][1], vv[1][2],
                    vv[2][0], vv[2][1], vv[2][2],
                    rti_pkg::CW'(nrm[0]), rti_pkg::CW'(nrm[1]), rti_pkg::CW'(nrm[2]));
  endfunction

  function automatic rti_pkg::in_t noise_tri();
    rti_pkg::in_t t;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return t;
  endfunction

  initial begin
    logic [rti_pkg::CW-1:0] one, five, mx, mn;
    one = 32'h0001_0000;
    five = 32'h0005_0000;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_mode = 0;
    for (int k = 0; k < 3; k++) begin
      ray_org[k] = '0;
      ray_dir[k] = '0;
    end
    ray_dir[0] = rti_pkg::DIR_X_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed triangles against the reset ray along +x from the origin.
    // Hit exactly on a vertex, so the first edge product vanishes.
    triangle_q.push_back(make_tri(five, 0, 0, five, one, 0, five, 0, one, one, 0, 0));
    // Hit in the interior.
    triangle_q.push_back(make_tri(five, -one, -one, five, one, -one, five, 0, one, one, 0, 0));
    // Same triangle with the normal flipped.
    triangle_q.push_back(make_tri(five, -one, -one, five, one, -one, five, 0, one, -one, 0, 0));
    // Plane point outside the triangle.
    triangle_q.push_back(make_tri(five, one, one, five, 2 * one, one, five, one, 2 * one,
                                  one, 0, 0));
    // Ray parallel to the plane.
    triangle_q.push_back(make_tri(five, -one, -one, five, one, -one, five, 0, one, 0, one, 0));
    // Plane behind the origin.
    triangle_q.push_back(make_tri(-five, -one, -one, -five, one, -one, -five, 0, one,
                                  one, 0, 0));
    // Plane through the origin.
    triangle_q.push_back(make_tri(0, -one, -one, 0, one, -one, 0, 0, one, one, 0, 0));
    // Degenerate triangle: all vertices equal.
    triangle_q.push_back(make_tri(five, one, one, five, one, one, five, one, one, one, 0, 0));
    // Far plane with a tiny normal component along the ray, which puts the point at the top of the range.
    triangle_q.push_back(make_tri(mx, 0, 0, mx, one, 0, mx, 0, one, 1, mx, mx));
    triangle_q.push_back(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    triangle_q.push_back(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    triangle_q.push_back(make_tri(mx, mn, mx, mn, mx, mn, mx, mn, mx, mn, mx, mn));
    triangle_q.push_back('0);
    triangle_q.push_back('1);
    drain();

    // Ray set to the extremes: direction so steep that the point saturates.
    set_ray(mx, mn, 0, mn, mx, one);
    triangle_q.push_back(make_tri(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one));
    triangle_q.push_back(make_tri(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, -one));
    triangle_q.push_back(make_tri(mn, mx, 0, mn, mx, one, mn, mx, -one, one, 1, 0));
    triangle_q.push_back(make_tri(mx, mx, mx, mn, mn, mn, 0, 0, 0, mx, mn, mx));
    triangle_q.push_back(noise_tri());
    triangle_q.push_back(noise_tri());
    // Writes beyond the last register must leave the ray alone.
    drain();
    write_reg(rti_pkg::REG_DIRECTION_Z + 3'd1, mx);
    write_reg(rti_pkg::REG_DIRECTION_Z + 3'd2, mn);
    triangle_q.push_back(make_tri(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one));
    drain();

    // Random part: six settings of the ray, two per idling pattern.
    for (int run = 0; run < 6; run++) begin
      idle_mode = run / 2;
      case (run)
        0: set_ray(0, 0, 0, rti_pkg::DIR_X_RESET, 0, 0);
        1: set_ray(small_val(1 << 22), small_val(1 << 22), small_val(1 << 22),
                   small_val(1 << 20), small_val(1 << 20), small_val(1 << 20));
        2: set_ray(mn, mx, mn, mx, mn, mx);
        3: set_ray(small_val(1 << 24), small_val(1 << 24), small_val(1 << 24),
                   small_val(1 << 18), small_val(1 << 18), small_val(1 << 18));
        4: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_ray(small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
                         small_val(1 << 21), small_val(1 << 21), small_val(1 << 21));
      endcase
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        if ($urandom_range(0, 99) < 80) triangle_q.push_back(ray_tri());
        else triangle_q.push_back(noise_tri());
      end
      drain();
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
